/* src/aes_pkg.sv */
// Shared constants, S-box tables and GF(2^8) helpers for the AES-128 cipher.
package aes_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int NUM_RK     = NUM_ROUNDS + 1;
  localparam int RK_IDX_W   = $clog2(NUM_RK);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[11'd2047 - {x, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return INV_SBOX_TBL[11'd2047 - {x, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // The multiplier is always a constant, so this folds into a few XOR terms.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] t;
    p = 8'h00;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ t;
      t = xtime(t);
    end
    return p;
  endfunction

endpackage

/* src/aes_if.sv */
// Channel interfaces: block input, result output and configuration writes.
interface aes_blk_in_if;
  import aes_pkg::*;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source(output valid, mode, block_high, block_low, input ready);
  modport sink(input valid, mode, block_high, block_low, output ready);
endinterface

interface aes_blk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source(output valid, result_high, result_low, input ready);
  modport sink(input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  import aes_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* src/aes_key_sched.sv */
// Key registers and iterative key expansion, one round key per cycle.
module aes_key_sched
  import aes_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  aes_cfg_if.sink             cfg,
  input  logic [RK_IDX_W-1:0] rk_idx,
  output logic [127:0]        rk,
  output logic                busy
);

  logic [63:0]         key_high;
  logic [63:0]         key_low;
  logic [127:0]        cur;
  logic [127:0]        cur_next;
  logic [127:0]        new_key;
  logic [7:0]          rcon;
  logic [RK_IDX_W-1:0] kcnt;
  logic                start;
  logic [127:0]        rk_mem [NUM_RK];
  logic [31:0]         t;

  assign cfg.ready = 1'b1;
  assign start = cfg.valid &&
                 (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW);
  assign new_key = (cfg.index == REG_KEY_HIGH) ? {cfg.data, key_low} : {key_high, cfg.data};

  always_comb begin
    t = {sbox(cur[23:16]), sbox(cur[15:8]), sbox(cur[7:0]), sbox(cur[31:24])};
    t[31:24] = t[31:24] ^ rcon;
    cur_next[127:96] = cur[127:96] ^ t;
    cur_next[95:64]  = cur[95:64] ^ cur_next[127:96];
    cur_next[63:32]  = cur[63:32] ^ cur_next[95:64];
    cur_next[31:0]   = cur[31:0] ^ cur_next[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      busy     <= 1'b0;
      kcnt     <= '0;
    end else if (start) begin
      if (cfg.index == REG_KEY_HIGH) key_high <= cfg.data;
      else key_low <= cfg.data;
      busy <= 1'b1;
      kcnt <= RK_IDX_W'(1);
    end else if (busy) begin
      if (kcnt == RK_IDX_W'(NUM_ROUNDS)) busy <= 1'b0;
      else kcnt <= kcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rk_mem[0] <= new_key;
      cur       <= new_key;
      rcon      <= 8'h01;
    end else if (busy) begin
      rk_mem[kcnt] <= cur_next;
      cur          <= cur_next;
      rcon         <= xtime(rcon);
    end
  end

  assign rk = rk_mem[rk_idx];

endmodule

/* src/aes_round.sv */
// One forward or inverse AES round, shared by all rounds of a block.
module aes_round
  import aes_pkg::*;
(
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         dec,
  input  logic         skip_mix,
  output logic [127:0] state_out
);

  logic [7:0] s  [16];
  logic [7:0] a  [16];
  logic [7:0] b  [16];
  logic [7:0] m  [16];
  logic [7:0] k  [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8*i -: 8];
      k[i] = round_key[127 - 8*i -: 8];
    end
    // Substitution and row shift; the inverse path applies the round key
    // before the column mix.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) a[c*4 + r] = inv_sbox(s[((c - r) & 3)*4 + r]) ^ k[c*4 + r];
        else     a[c*4 + r] = sbox(s[((c + r) & 3)*4 + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          m[c*4 + r] = gf_mul(8'd14, a[c*4 + r]) ^ gf_mul(8'd11, a[c*4 + ((r + 1) & 3)]) ^
                       gf_mul(8'd13, a[c*4 + ((r + 2) & 3)]) ^
                       gf_mul(8'd9, a[c*4 + ((r + 3) & 3)]);
        end else begin
          m[c*4 + r] = gf_mul(8'd2, a[c*4 + r]) ^ gf_mul(8'd3, a[c*4 + ((r + 1) & 3)]) ^
                       a[c*4 + ((r + 2) & 3)] ^ a[c*4 + ((r + 3) & 3)];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      b[i] = skip_mix ? a[i] : m[i];
      if (!dec) b[i] = b[i] ^ k[i];
      state_out[127 - 8*i -: 8] = b[i];
    end
  end

endmodule

/* src/aes128_block_cipher.sv */
// Top level of the iterative AES-128 cipher with key schedule and round unit.
//
// Usage: write the 128-bit key through cfg, index 0 for key bytes 0..7 and
// index 1 for bytes 8..15. Each key write starts a key expansion that keeps
// the 11 round keys; blk is not ready meanwhile. A blk transaction carries
// one 128-bit block and mode (0 encrypt, 1 decrypt). The block gets its
// initial key addition on acceptance and then one round per cycle through a
// single shared round unit. The result appears on res after the last round
// and is held until the receiver takes it; a stalled receiver simply holds
// the block in that state. One block is processed at a time, so a new block
// can be taken in the cycle after the result transaction at the earliest.
// Reset clears the key registers and the sequencer; round keys are valid
// only after the first key write.
module aes128_block_cipher
  import aes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  aes_cfg_if.sink    cfg,
  aes_blk_in_if.sink blk,
  aes_blk_out_if.source res
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t              state;
  logic [127:0]        work;
  logic                dec;
  logic [RK_IDX_W-1:0] cnt;
  logic [RK_IDX_W-1:0] rk_idx;
  logic [127:0]        rk;
  logic [127:0]        round_out;
  logic                ks_busy;
  logic                last;

  aes_key_sched u_key_sched (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .rk_idx (rk_idx),
    .rk     (rk),
    .busy   (ks_busy)
  );

  assign last = (cnt == RK_IDX_W'(NUM_ROUNDS));

  aes_round u_round (
    .state_in  (work),
    .round_key (rk),
    .dec       (dec),
    .skip_mix  (last),
    .state_out (round_out)
  );

  always_comb begin
    if (state == IDLE) rk_idx = blk.mode ? RK_IDX_W'(NUM_ROUNDS) : '0;
    else rk_idx = dec ? RK_IDX_W'(NUM_ROUNDS) - cnt : cnt;
  end

  assign blk.ready       = (state == IDLE) && !ks_busy;
  assign res.valid       = (state == DONE);
  assign res.result_high = work[127:64];
  assign res.result_low  = work[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      dec   <= 1'b0;
      work  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (blk.valid && blk.ready) begin
            work  <= {blk.block_high, blk.block_low} ^ rk;
            dec   <= blk.mode;
            cnt   <= RK_IDX_W'(1);
            state <= RUN;
          end
        end
        RUN: begin
          work <= round_out;
          if (last) begin
            cnt   <= '0;
            state <= DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        DONE: begin
          if (res.ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* src/aes_chk.sv */
// Port-level checker for the AES-128 cipher, bound to the top level.
module aes_chk
  import aes_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 blk_valid,
  input logic                 blk_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [63:0]          res_high,
  input logic [63:0]          res_low
);

  // A block occupies the cipher until its result has been taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready |=> !blk_ready && !res_valid)
    else $error("cipher accepted work or showed a result right after a block");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !blk_ready)
    else $error("input ready while a result is pending");

  // A key write starts an expansion that blocks new input.
  a_key_write_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)
    |=> !blk_ready)
    else $error("input ready during key expansion");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_high) && $stable(res_low))
    else $error("stalled result changed or dropped");

endmodule

bind aes128_block_cipher aes_chk u_aes_chk (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_index (cfg.index),
  .blk_valid (blk.valid),
  .blk_ready (blk.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_high  (res.result_high),
  .res_low   (res.result_low)
);

/* dv/aes128_block_cipher_tb.sv */
// Self-checking testbench for the AES-128 block cipher: directed vectors, then random blocks.
`timescale 1ns / 100ps

module aes128_block_cipher_tb;
  import aes_pkg::*;

  typedef struct {
    logic        mode;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic        known;   // expected value given in the row
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vector_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam int NUM_RANDOM = 1430;

  logic clk;
  logic rst;

  aes_cfg_if     cfg();
  aes_blk_in_if  blk();
  aes_blk_out_if res();

  aes128_block_cipher i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg.sink),
    .blk(blk.sink),
    .res(res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [7:0]  round_key [0:NUM_RK-1][0:15];
  block_t      expected_q[$];
  int          error_cnt;
  bit          stim_done;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    error_cnt++;
  endtask

  function automatic logic [7:0] mul_gf(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // The S-box is computed from its definition: inverse as a^254, then the affine map.
  function automatic logic [7:0] inv_gf(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = mul_gf(r, a);
    return r;
  endfunction

  logic [7:0] fwd_sub [0:255];
  logic [7:0] inv_sub [0:255];

  function automatic logic [7:0] rl(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  task automatic build_sub_tables();
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = inv_gf(x[7:0]);
      fwd_sub[x] = b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = x[7:0];
  endtask

  task automatic expand_round_keys();
    logic [31:0] w [0:4*NUM_RK-1];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    w[0] = key_hi_q[63:32];
    w[1] = key_hi_q[31:0];
    w[2] = key_lo_q[63:32];
    w[3] = key_lo_q[31:0];
    for (int i = 4; i < 4 * NUM_RK; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
        t[31:24] ^= rc;
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int k = 0; k < NUM_RK; k++)
      for (int b = 0; b < 16; b++)
        round_key[k][b] = w[4*k + b/4][31 - 8*(b%4) -: 8];
  endtask

  function automatic block_t cipher_block(input logic mode, input logic [63:0] hi,
                                         input logic [63:0] lo);
    logic [7:0] st [0:15];
    logic [7:0] tmp [0:15];
    logic [7:0] col [0:3];
    logic [7:0] fm [0:3];
    logic [7:0] im [0:3];
    logic       dec;
    int         rk;
    block_t     r;
    fm = '{8'd2, 8'd3, 8'd1, 8'd1};
    im = '{8'd14, 8'd11, 8'd13, 8'd9};
    dec = (mode == MODE_DEC);
    for (int i = 0; i < 8; i++) begin
      st[i]     = hi[63 - 8*i -: 8];
      st[8 + i] = lo[63 - 8*i -: 8];
    end
    rk = dec ? NUM_ROUNDS : 0;
    for (int i = 0; i < 16; i++) st[i] ^= round_key[rk][i];
    for (int n = 1; n <= NUM_ROUNDS; n++) begin
      rk = dec ? NUM_ROUNDS - n : n;
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++)
          if (dec) tmp[((c + q) % 4) * 4 + q] = st[c*4 + q];
          else     tmp[c*4 + q] = st[((c + q) % 4) * 4 + q];
      for (int i = 0; i < 16; i++) st[i] = dec ? inv_sub[tmp[i]] : fwd_sub[tmp[i]];
      // Encryption mixes before the key addition, decryption after it.
      if (dec) for (int i = 0; i < 16; i++) st[i] ^= round_key[rk][i];
      if (n != NUM_ROUNDS) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) col[j] = st[c*4 + j];
          for (int q = 0; q < 4; q++) begin
            st[c*4 + q] = 8'h00;
            for (int j = 0; j < 4; j++)
              st[c*4 + q] ^= mul_gf(dec ? im[(j - q + 4) % 4] : fm[(j - q + 4) % 4], col[j]);
          end
        end
      end
      if (!dec) for (int i = 0; i < 16; i++) st[i] ^= round_key[rk][i];
    end
    for (int i = 0; i < 8; i++) begin
      r.hi[63 - 8*i -: 8] = st[i];
      r.lo[63 - 8*i -: 8] = st[8 + i];
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else if (idx == REG_KEY_LOW) key_lo_q = val;
    else return;
    expand_round_keys();
  endtask

  // Waits for all results, then a little longer so the block is idle.
  task automatic drain();
    blk.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo,
                            input logic known, input logic [63:0] ehi, input logic [63:0] elo);
    block_t e;
    int g;
    g = gap_len();
    // Keep valid up when the next transaction follows at once.
    if (g != 0) blk.valid <= 1'b0;
    repeat (g) @(posedge clk);
    blk.valid      <= 1'b1;
    blk.mode       <= mode;
    blk.block_high <= hi;
    blk.block_low  <= lo;
    do @(posedge clk); while (!blk.ready);
    if (known) begin
      e.hi = ehi;
      e.lo = elo;
    end else begin
      e = cipher_block(mode, hi, lo);
    end
    expected_q.push_back(e);
  endtask

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    block_t e;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", res.result_high, 64'h0);
        end else begin
          e = expected_q.pop_front();
          if (res.result_high !== e.hi) report_mismatch("result_high", res.result_high, e.hi);
          if (res.result_low !== e.lo) report_mismatch("result_low", res.result_low, e.lo);
        end
      end
      res.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0 && 1'b1);
    end
  end

  vector_t directed[$];

  initial begin
    logic [63:0] h;
    logic [63:0] l;
    logic        m;
    rst = 1'b1;
    clk = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_KEY_HIGH;
    cfg.data = '0;
    blk.valid = 1'b0;
    blk.mode = MODE_ENC;
    blk.block_high = '0;
    blk.block_low = '0;
    res.ready = 1'b0;
    error_cnt = 0;
    stim_done = 1'b0;
    key_hi_q = '0;
    key_lo_q = '0;
    build_sub_tables();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Standard test vector: key 000102..0f, plaintext 0011..ff.
    write_key_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_key_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    directed = '{
      '{MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{MODE_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{MODE_ENC, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
      '{MODE_ENC, '1, '1, 1'b0, 64'h0, 64'h0},
      '{MODE_DEC, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
      '{MODE_DEC, '1, '1, 1'b0, 64'h0, 64'h0},
      '{MODE_ENC, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0},
      '{MODE_DEC, 64'h1, 64'h8000000000000000, 1'b0, 64'h0, 64'h0}
    };
    foreach (directed[i])
      send_block(directed[i].mode, directed[i].blk_hi, directed[i].blk_lo,
                 directed[i].known, directed[i].exp_hi, directed[i].exp_lo);
    drain();

    // Key extremes: all zeros, all ones, then a partial update of one half.
    write_key_reg(REG_KEY_HIGH, 64'h0);
    write_key_reg(REG_KEY_LOW, 64'h0);
    send_block(MODE_ENC, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
    send_block(MODE_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0);
    drain();
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LOW, '1);
    send_block(MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 0, 0);
    send_block(MODE_DEC, '1, 64'h0, 1'b0, 0, 0);
    drain();
    write_key_reg(REG_KEY_LOW, 64'h5555aaaa5555aaaa);
    send_block(MODE_ENC, 64'hdeadbeef00000000, 64'h00000000cafef00d, 1'b0, 0, 0);
    drain();
    // An index past the last register is ignored.
    write_key_reg(2'd3, 64'h1234);
    write_key_reg(2'd2, 64'hffff);
    send_block(MODE_DEC, 64'h1, 64'h2, 1'b0, 0, 0);
    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 200 == 0) begin
        drain();
        if ($urandom_range(0, 3) != 0)
          write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
        write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
      end
      m = $urandom_range(0, 1);
      h = {$urandom, $urandom};
      l = {$urandom, $urandom};
      // Half the decryptions undo a fresh encryption, so round trips get exercised.
      if (m == MODE_DEC && $urandom_range(0, 1) == 0) begin
        block_t c;
        c = cipher_block(MODE_ENC, h, l);
        h = c.hi;
        l = c.lo;
      end
      send_block(m, h, l, 1'b0, 0, 0);
    end
    drain();
    stim_done = 1'b1;
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
src/aes_pkg.sv
src/aes_if.sv
src/aes_key_sched.sv
src/aes_round.sv
src/aes128_block_cipher.sv
src/aes_chk.sv
dv/aes128_block_cipher_tb.sv
